[rtl/bxavg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxavg_pkg
// Shared constants and types of the box average downscaler.
// ----------------------------------------------------------------------------
package bxavg_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int SUM_BITS   = 24;
   localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
   localparam int REG_BITS   = 13;
   localparam int POS_BITS   = 12;
   localparam int HEIGHT_MAX = 4096;
   localparam int CNT_BITS   = 25;              // rows x cols, up to 2^24
   localparam int DIVD_BITS  = SUM_BITS + 2;    // sum plus half the count
   localparam int Q_BITS     = 9;
   localparam int STEP_BITS  = 4;
   localparam int IDX_BITS   = 8;

   // register indexes
   localparam logic [IDX_BITS-1:0] REG_SRC_W = 8'd0;
   localparam logic [IDX_BITS-1:0] REG_SRC_H = 8'd1;
   localparam logic [IDX_BITS-1:0] REG_TGT_W = 8'd2;
   localparam logic [IDX_BITS-1:0] REG_TGT_H = 8'd3;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_ACCUM = 6'b000100,
      ST_PREP  = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   typedef struct packed {
      logic accept;      // pixel transfer, issue line store read
      logic accum;       // add pixel, write back, advance position
      logic prep;        // form dividends
      logic div_step;    // one quotient bit
      logic load_out;    // move averages into output register
      logic clear_step;  // write one zero entry
   } cmd_type;

   typedef struct packed {
      logic closes;      // current pixel closes its box
      logic div_done;    // last quotient bit taken this cycle
      logic clear_done;  // last entry being cleared
   } status_type;

endpackage

[rtl/bxavg_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxavg_ctrl
// Sequencer: line store clearing, per-pixel accumulate and average divide.
// ----------------------------------------------------------------------------
module bxavg_ctrl
   import bxavg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       restart,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   // command decode
   always_comb begin
      cmd            = '0;
      cmd.accept     = (state_ff == ST_IDLE) && req_tvalid;
      cmd.accum      = (state_ff == ST_ACCUM);
      cmd.prep       = (state_ff == ST_PREP);
      cmd.div_step   = (state_ff == ST_DIV);
      cmd.load_out   = (state_ff == ST_EMIT) && out_free;
      cmd.clear_step = (state_ff == ST_CLEAR);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE:  if (req_tvalid) state_in = ST_ACCUM;
         ST_ACCUM: state_in = status.closes ? ST_PREP : ST_IDLE;
         ST_PREP:  state_in = ST_DIV;
         ST_DIV:   if (status.div_done) state_in = ST_EMIT;
         ST_EMIT:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
      if (restart) state_in = ST_CLEAR;
   end

   // output valid
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_tready) rsp_tvalid_in = 1'b0;
      if (cmd.load_out) rsp_tvalid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

endmodule

[rtl/bxavg_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxavg_datapath
// Size registers, incremental coordinate mapping, line store of sums and
// a radix-2 divider with three channel lanes.
// ----------------------------------------------------------------------------
module bxavg_datapath
   import bxavg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [IDX_BITS-1:0] csr_index,
   input  logic [REG_BITS-1:0] csr_wdata,
   output logic                restart,
   input  logic [23:0]         req_tdata,
   input  cmd_type             cmd,
   output status_type          status,
   output logic [47:0]         rsp_tdata,
   output logic                rsp_tlast
);

   localparam int E_BITS = REG_BITS + 2;

   logic [REG_BITS-1:0] src_w_ff, src_h_ff, tgt_w_ff, tgt_h_ff;
   logic [REG_BITS-1:0] sw, sh, tw, th;

   // position state
   logic [POS_BITS-1:0] x_ff, y_ff, dx_ff, dy_ff;
   logic [E_BITS-1:0]   ex_ff, ey_ff;
   logic [REG_BITS-1:0] cols_ff, rows_ff;
   logic [ADDR_BITS-1:0] clr_ff;

   // pixel and sums
   logic [23:0]            pix_ff;
   logic [3*SUM_BITS-1:0]  mem [MAX_WIDTH];
   logic [3*SUM_BITS-1:0]  rd_ff;
   logic [SUM_BITS-1:0]    sum_in [3];
   logic [SUM_BITS-1:0]    sum_ff [3];
   logic [CNT_BITS-1:0]    count_ff;
   logic [POS_BITS-1:0]    odx_ff, ody_ff;
   logic                   oend_ff;

   // divider
   logic [DIVD_BITS-1:0]   rem_ff [3];
   logic [Q_BITS-1:0]      q_ff [3];
   logic [STEP_BITS-1:0]   step_ff;
   logic [DIVD_BITS+Q_BITS-1:0] dvs;

   // output register
   logic [47:0] out_ff;
   logic        last_ff;

   logic last_col, last_row, col_closes, row_closes;
   logic [E_BITS-1:0] ex_next, ey_next;
   logic ex_wrap, ey_wrap;
   logic mem_we;
   logic [ADDR_BITS-1:0] mem_addr;
   logic [3*SUM_BITS-1:0] mem_wdata;

   assign restart = csr_we && (csr_index == REG_SRC_W || csr_index == REG_SRC_H ||
                               csr_index == REG_TGT_W || csr_index == REG_TGT_H);

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= REG_BITS'(1);
         src_h_ff <= REG_BITS'(1);
         tgt_w_ff <= REG_BITS'(1);
         tgt_h_ff <= REG_BITS'(1);
      end else if (csr_we) begin
         case (csr_index)
            REG_SRC_W: src_w_ff <= csr_wdata;
            REG_SRC_H: src_h_ff <= csr_wdata;
            REG_TGT_W: tgt_w_ff <= csr_wdata;
            REG_TGT_H: tgt_h_ff <= csr_wdata;
            default:   ;
         endcase
      end
   end

   // clamped sizes
   always_comb begin
      sw = (src_w_ff == '0) ? REG_BITS'(1) :
           (src_w_ff > REG_BITS'(MAX_WIDTH)) ? REG_BITS'(MAX_WIDTH) : src_w_ff;
      sh = (src_h_ff == '0) ? REG_BITS'(1) :
           (src_h_ff > REG_BITS'(HEIGHT_MAX)) ? REG_BITS'(HEIGHT_MAX) : src_h_ff;
      tw = (tgt_w_ff == '0) ? REG_BITS'(1) : (tgt_w_ff > sw) ? sw : tgt_w_ff;
      th = (tgt_h_ff == '0) ? REG_BITS'(1) : (tgt_h_ff > sh) ? sh : tgt_h_ff;
   end

   // box closing: residual plus 2*target reaching 2*source moves the mapping
   always_comb begin
      last_col   = ({1'b0, x_ff} + 13'd1) >= sw;
      last_row   = ({1'b0, y_ff} + 13'd1) >= sh;
      ex_next    = ex_ff + {1'b0, tw, 1'b0};
      ey_next    = ey_ff + {1'b0, th, 1'b0};
      ex_wrap    = ex_next >= {1'b0, sw, 1'b0};
      ey_wrap    = ey_next >= {1'b0, sh, 1'b0};
      col_closes = last_col || ex_wrap;
      row_closes = last_row || ey_wrap;
   end

   assign status.closes     = col_closes && row_closes;
   assign status.clear_done = cmd.clear_step && (clr_ff == {ADDR_BITS{1'b1}});
   assign status.div_done   = cmd.div_step && (step_ff == '0);

   // position and run counters, residuals reloaded from the new sizes while clearing
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         x_ff    <= '0;
         y_ff    <= '0;
         dx_ff   <= '0;
         dy_ff   <= '0;
         ex_ff   <= E_BITS'(tw);
         ey_ff   <= E_BITS'(th);
         cols_ff <= '0;
         rows_ff <= '0;
      end else if (cmd.clear_step) begin
         ex_ff   <= E_BITS'(tw);
         ey_ff   <= E_BITS'(th);
      end else if (cmd.accum) begin
         if (last_col) begin
            x_ff    <= '0;
            dx_ff   <= '0;
            ex_ff   <= E_BITS'(tw);
            cols_ff <= '0;
            if (last_row) begin
               y_ff    <= '0;
               dy_ff   <= '0;
               ey_ff   <= E_BITS'(th);
               rows_ff <= '0;
            end else begin
               y_ff    <= y_ff + 1'b1;
               rows_ff <= row_closes ? '0 : rows_ff + 1'b1;
               if (ey_wrap) begin
                  ey_ff <= ey_next - {1'b0, sh, 1'b0};
                  dy_ff <= dy_ff + 1'b1;
               end else begin
                  ey_ff <= ey_next;
               end
            end
         end else begin
            x_ff    <= x_ff + 1'b1;
            cols_ff <= col_closes ? '0 : cols_ff + 1'b1;
            if (ex_wrap) begin
               ex_ff <= ex_next - {1'b0, sw, 1'b0};
               dx_ff <= dx_ff + 1'b1;
            end else begin
               ex_ff <= ex_next;
            end
         end
      end
   end

   // clearing sweep address
   always_ff @(posedge clock) begin
      if (reset || restart) clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
   end

   // saturating channel sums
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [SUM_BITS:0] s;
         s = {1'b0, rd_ff[c*SUM_BITS +: SUM_BITS]} + (SUM_BITS+1)'(pix_ff[c*8 +: 8]);
         sum_in[c] = s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
      end
   end

   // line store port
   always_comb begin
      mem_we    = cmd.clear_step || cmd.accum;
      mem_addr  = cmd.clear_step ? clr_ff : ADDR_BITS'(dx_ff);
      mem_wdata = (cmd.clear_step || status.closes) ? '0 :
                  {sum_in[2], sum_in[1], sum_in[0]};
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      if (cmd.accept) rd_ff <= mem[ADDR_BITS'(dx_ff)];
   end

   // pixel capture
   always_ff @(posedge clock) begin
      if (cmd.accept) pix_ff <= req_tdata;
   end

   // box capture: sums, pixel count and coordinates
   always_ff @(posedge clock) begin
      if (cmd.accum) begin
         for (int c = 0; c < 3; c++) sum_ff[c] <= sum_in[c];
         count_ff <= (CNT_BITS'(rows_ff) + CNT_BITS'(1)) *
                     (CNT_BITS'(cols_ff) + CNT_BITS'(1));
         odx_ff   <= dx_ff;
         ody_ff   <= dy_ff;
         oend_ff  <= last_col && last_row;
      end
   end

   // restoring divider, one quotient bit per cycle on each lane
   assign dvs = (DIVD_BITS+Q_BITS)'(count_ff) << step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.prep) begin
         step_ff <= STEP_BITS'(Q_BITS - 1);
      end else if (cmd.div_step && step_ff != '0) begin
         step_ff <= step_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (cmd.prep) begin
            rem_ff[c] <= DIVD_BITS'(sum_ff[c]) + DIVD_BITS'(count_ff >> 1);
            q_ff[c]   <= '0;
         end else if (cmd.div_step) begin
            if ((DIVD_BITS+Q_BITS)'(rem_ff[c]) >= dvs) begin
               rem_ff[c] <= rem_ff[c] - DIVD_BITS'(dvs);
               q_ff[c][step_ff] <= 1'b1;
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         for (int c = 0; c < 3; c++)
            out_ff[c*8 +: 8] <= q_ff[c][Q_BITS-1] ? 8'hFF : q_ff[c][7:0];
         out_ff[35:24] <= odx_ff;
         out_ff[47:36] <= ody_ff;
         last_ff       <= oend_ff;
      end
   end

   assign rsp_tdata = out_ff;
   assign rsp_tlast = last_ff;

endmodule

[rtl/box_average_downscale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_downscale
// Streaming box-filter downscaler for 8-bit RGB pixels in raster order.
//
//  channel   ports                          moves
//  req       req_tvalid/tready/tdata        one source pixel
//  rsp       rsp_tvalid/tready/tdata/tlast  one averaged destination pixel
//  csr       csr_we/csr_index/csr_wdata     one size register write
//
// A pixel is handled as a line store read, then an add and write back.
// A pixel that closes a box then forms its dividends, runs through the
// one-bit-per-cycle divider and waits for a free output. After reset and
// each size register write the line store is cleared, during which no pixel is taken.
// A held result does not stop pixel transfers until the next average is due.
// ----------------------------------------------------------------------------
module box_average_downscale
   import bxavg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,   // in_red, in_green, in_blue
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [47:0]         rsp_tdata,   // out_red, out_green, out_blue, out_column, out_row
   output logic                rsp_tlast,   // frame_end
   input  logic                csr_we,
   input  logic [IDX_BITS-1:0] csr_index,
   input  logic [REG_BITS-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       restart;

   // sequencer
   bxavg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // sums, mapping and divider
   bxavg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .restart   (restart),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule
